// ----- hdl/hq_pkg.sv -----
package hq_pkg;

   localparam int BINS       = 1024;
   localparam int COUNT_BITS = 24;
   localparam int BIN_BITS   = $clog2(BINS);
   localparam int FRAC_BITS  = 16;
   localparam int PFRAC_BITS = FRAC_BITS + 1;
   localparam int POS_BITS   = PFRAC_BITS + COUNT_BITS;
   localparam int OUT_BITS   = 26;
   localparam int PROD_BITS  = BIN_BITS + PFRAC_BITS;

   localparam logic [PFRAC_BITS-1:0] FRAC_ONE = PFRAC_BITS'(1 << FRAC_BITS);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [9:0]            sample_value;
      logic [PFRAC_BITS-1:0] quantile_fraction;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] quantile_value;
      logic                empty_error;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [BIN_BITS-1:0]   v0;
      logic [BIN_BITS-1:0]   v1;
      logic [PFRAC_BITS-1:0] rest;
   } mix_in_type;

   typedef struct packed {
      logic                valid;
      logic [OUT_BITS-1:0] value;
   } mix_out_type;

endpackage

// ----- hdl/hq_ram.sv -----
module hq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/hq_mix.sv -----
module hq_mix (
   input  logic                clock,
   input  logic                reset,
   input  hq_pkg::mix_in_type  mix_in,
   output hq_pkg::mix_out_type mix_out
);
   import hq_pkg::*;

   logic                 vld1_ff, vld1_in;
   logic                 vld2_ff, vld2_in;
   logic [PROD_BITS-1:0] prod0_ff, prod0_in;
   logic [PROD_BITS-1:0] prod1_ff, prod1_in;
   logic [OUT_BITS-1:0]  sum_ff, sum_in;
   logic [PROD_BITS:0]   sum_full;

   always_comb begin
      prod0_in = PROD_BITS'(mix_in.v0) * PROD_BITS'(FRAC_ONE - mix_in.rest);
      prod1_in = PROD_BITS'(mix_in.v1) * PROD_BITS'(mix_in.rest);
      vld1_in  = mix_in.valid;
      sum_full = {1'b0, prod0_ff} + {1'b0, prod1_ff};
      sum_in   = sum_full[OUT_BITS-1:0];
      vld2_in  = vld1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         vld2_ff <= vld2_in;
      end
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      sum_ff   <= sum_in;
   end

   assign mix_out.valid = vld2_ff;
   assign mix_out.value = sum_ff;

endmodule

// ----- hdl/histogram_quantile.sv -----
// Histogram with linear-interpolated quantile query.
// Input words are taken with start while busy is low. An insert word
// (op = 0) adds its sample to the histogram and the total count and gives
// no result; an insert at full count is dropped. A query word (op = 1)
// gives one result word on rsp_word, marked by rsp_valid for one cycle.
// An insert that is not dropped keeps busy high in state INS_WR, for the
// read-modify-write of its bin counter in the bin memory.
// A query on an empty store answers in the cycle after acceptance with
// empty_error set. Otherwise the query computes its ranks in state Q_POS,
// then scans the bin memory one bin per cycle, as the single read port of
// the bin memory allows, up to and including the bin of the upper rank,
// then interpolates in the product and sum registers of hq_mix.
// The result appears in the cycle in which busy falls again.
// After reset, busy stays high while the bin memory is cleared one entry
// per cycle. The receiver cannot stall; each result word is shown for
// exactly one cycle.
module histogram_quantile (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  hq_pkg::req_type req_word,
   output logic            rsp_valid,
   output hq_pkg::rsp_type rsp_word
);
   import hq_pkg::*;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      INS_WR,
      Q_POS,
      Q_SCAN,
      Q_MIX
   } state_type;

   state_type             state_ff, state_in;
   logic [BIN_BITS-1:0]   addr_ff, addr_in;
   logic                  scan_end_ff, scan_end_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [BIN_BITS-1:0]   idx_ff, idx_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] cum_ff, cum_in;
   logic [COUNT_BITS-1:0] tgt0_ff, tgt0_in;
   logic [COUNT_BITS-1:0] tgt1_ff, tgt1_in;
   logic [POS_BITS-1:0]   position_ff, position_in;
   logic [PFRAC_BITS-1:0] rest_ff, rest_in;
   logic                  found0_ff, found0_in;
   logic [BIN_BITS-1:0]   v0_ff, v0_in;
   logic [BIN_BITS-1:0]   v1_ff, v1_in;
   logic                  mix_go_ff, mix_go_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic [PFRAC_BITS-1:0] frac_sat;
   logic [POS_BITS-PFRAC_BITS:0] pos_full;
   logic [COUNT_BITS-1:0] lim;
   logic [COUNT_BITS-1:0] pos;
   logic [POS_BITS-1:0]   rest_full;
   logic [COUNT_BITS-1:0] cum_next;
   logic                  wr_en;
   logic [BIN_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [BIN_BITS-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] rd_data;
   mix_in_type            mix_in;
   mix_out_type           mix_out;

   hq_ram #(
      .DEPTH(BINS),
      .WIDTH(COUNT_BITS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign mix_in.valid = mix_go_ff;
   assign mix_in.v0    = v0_ff;
   assign mix_in.v1    = v1_ff;
   assign mix_in.rest  = rest_ff;

   hq_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .mix_in (mix_in),
      .mix_out(mix_out)
   );

   assign accept = start && (state_ff == IDLE);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      scan_end_in  = scan_end_ff;
      rd_vld_in    = 1'b0;
      idx_in       = addr_ff;
      total_in     = total_ff;
      cum_in       = cum_ff;
      tgt0_in      = tgt0_ff;
      tgt1_in      = tgt1_ff;
      position_in  = position_ff;
      rest_in      = rest_ff;
      found0_in    = found0_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      mix_go_in    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data + COUNT_BITS'(1);
      rd_addr = addr_ff;

      frac_sat  = (req_word.quantile_fraction > FRAC_ONE) ? FRAC_ONE
                                                          : req_word.quantile_fraction;
      pos_full  = position_ff[POS_BITS-1:FRAC_BITS];
      lim       = total_ff - COUNT_BITS'(2);
      pos       = (pos_full > (POS_BITS-FRAC_BITS)'(lim)) ? lim
                                                          : pos_full[COUNT_BITS-1:0];
      rest_full = position_ff - POS_BITS'({pos, {FRAC_BITS{1'b0}}});
      cum_next  = cum_ff + rd_data;

      case (state_ff)
         CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            addr_in = addr_ff + BIN_BITS'(1);
            if (addr_ff == BIN_BITS'(BINS - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            rd_addr = BIN_BITS'(req_word.sample_value);
            if (accept) begin
               if (req_word.op == OP_INSERT) begin
                  addr_in = BIN_BITS'(req_word.sample_value);
                  if (32'(req_word.sample_value) < BINS && total_ff != '1) begin
                     state_in = INS_WR;
                  end
               end else if (total_ff == '0) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.quantile_value = '0;
                  rsp_in.empty_error    = 1'b1;
               end else begin
                  position_in = POS_BITS'(frac_sat) *
                                POS_BITS'(total_ff - COUNT_BITS'(1));
                  state_in    = Q_POS;
               end
            end
         end
         INS_WR: begin
            wr_en    = 1'b1;
            total_in = total_ff + COUNT_BITS'(1);
            state_in = IDLE;
         end
         Q_POS: begin
            if (total_ff == COUNT_BITS'(1)) begin
               tgt0_in = '0;
               tgt1_in = '0;
               rest_in = '0;
            end else begin
               tgt0_in = pos;
               tgt1_in = pos + COUNT_BITS'(1);
               rest_in = rest_full[PFRAC_BITS-1:0];
            end
            addr_in     = '0;
            scan_end_in = 1'b0;
            cum_in      = '0;
            found0_in   = 1'b0;
            state_in    = Q_SCAN;
         end
         Q_SCAN: begin
            if (!scan_end_ff) begin
               rd_vld_in = 1'b1;
               addr_in   = addr_ff + BIN_BITS'(1);
               if (addr_ff == BIN_BITS'(BINS - 1)) begin
                  scan_end_in = 1'b1;
               end
            end
            if (rd_vld_ff) begin
               cum_in = cum_next;
               if (!found0_ff && cum_next > tgt0_ff) begin
                  found0_in = 1'b1;
                  v0_in     = idx_ff;
               end
               if (cum_next > tgt1_ff) begin
                  v1_in     = idx_ff;
                  mix_go_in = 1'b1;
                  state_in  = Q_MIX;
               end
            end
         end
         Q_MIX: begin
            if (mix_out.valid) begin
               rsp_valid_in          = 1'b1;
               rsp_in.quantile_value = mix_out.value;
               rsp_in.empty_error    = 1'b0;
               state_in              = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         addr_ff      <= '0;
         scan_end_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         total_ff     <= '0;
         found0_ff    <= 1'b0;
         mix_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         scan_end_ff  <= scan_end_in;
         rd_vld_ff    <= rd_vld_in;
         total_ff     <= total_in;
         found0_ff    <= found0_in;
         mix_go_ff    <= mix_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      cum_ff      <= cum_in;
      tgt0_ff     <= tgt0_in;
      tgt1_ff     <= tgt1_in;
      position_ff <= position_in;
      rest_ff     <= rest_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef ASSERT_OFF
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.empty_error |-> rsp_word.quantile_value == '0)
      else $error("empty result word carries a value");

   a_insert_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.op == OP_INSERT |=> !rsp_valid)
      else $error("insert word produced a result");

   a_nonempty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.empty_error |-> total_ff != '0)
      else $error("quantile result with empty histogram");

   a_mix_in_state: assert property (@(posedge clock) disable iff (reset)
      mix_out.valid |-> state_ff == Q_MIX)
      else $error("interpolation finished outside the query");

   a_ranks_ordered: assert property (@(posedge clock) disable iff (reset)
      state_ff == Q_MIX |-> v0_ff <= v1_ff)
      else $error("lower rank bin above upper rank bin");
`endif

endmodule
